/* rtl/core/modular_inverse_extgcd_top_macros.svh */
// Assertion macros for the modular inverse block.
// Included by modular_inverse_extgcd_top; expects clk and rst_n in scope.
`ifndef MODULAR_INVERSE_EXTGCD_TOP_MACROS_SVH
`define MODULAR_INVERSE_EXTGCD_TOP_MACROS_SVH
`ifndef SYNTH
`define MIE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MIE_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MIE_ASSERT(lbl, prop, msg)
`define MIE_ASSERT_RST(lbl, prop, msg)
`endif
`endif

/* rtl/core/mie_pkg.sv */
// Shared types and constants for the modular inverse block.
// No dependencies; used by mie_divser and modular_inverse_extgcd_top.
package mie_pkg;

  localparam int unsigned WIDTH_DEF = 32;

  // Top-level sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_DIV,
    ST_RED,
    ST_FIX,
    ST_DONE
  } mie_state_t;

  // Serial divider states
  typedef enum logic [1:0] {
    DV_IDLE,
    DV_ALIGN,
    DV_SUB
  } div_state_t;

  // Divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

/* rtl/core/mie_divser.sv */
// Bit-serial divider: remainder of dividend/divisor and quotient*mult, one bit per cycle.
// Depends on mie_pkg.
module mie_divser #(
  parameter int unsigned WIDTH = mie_pkg::WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [WIDTH-1:0]    dividend,
  input  logic [WIDTH-1:0]    divisor,   // nonzero
  input  logic [WIDTH-1:0]    mult,
  output mie_pkg::div_status_t status,
  output logic [WIDTH-1:0]    rem,
  output logic [WIDTH-1:0]    acc
);
  import mie_pkg::*;

  localparam int unsigned CW = $clog2(WIDTH);

  div_state_t      state_r, state_nxt;
  logic [WIDTH-1:0] rem_r, dvs_r, acc_r, mult_r;
  logic [CW-1:0]    cnt_r;
  logic             done_r, done_nxt;
  logic [WIDTH-1:0] dvs_dbl;
  logic             can_shift, ge;

  assign dvs_dbl   = {dvs_r[WIDTH-2:0], 1'b0};
  assign can_shift = !dvs_r[WIDTH-1] && (dvs_dbl <= rem_r);
  assign ge        = (rem_r >= dvs_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DV_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      DV_IDLE: begin
        if (start) state_nxt = DV_ALIGN;
      end
      DV_ALIGN: begin
        if (!can_shift) state_nxt = DV_SUB;
      end
      DV_SUB: begin
        if (cnt_r == '0) begin
          state_nxt = DV_IDLE;
          done_nxt  = 1'b1;
        end
      end
      default: state_nxt = DV_IDLE;
    endcase
  end

  // Align divisor under the dividend MSB, then restore-subtract back down.
  // Quotient bits arrive MSB first and are folded into acc by Horner's rule.
  always_ff @(posedge clk) begin
    unique case (state_r)
      DV_IDLE: begin
        if (start) begin
          rem_r  <= dividend;
          dvs_r  <= divisor;
          mult_r <= mult;
          acc_r  <= '0;
          cnt_r  <= '0;
        end
      end
      DV_ALIGN: begin
        if (can_shift) begin
          dvs_r <= dvs_dbl;
          cnt_r <= cnt_r + 1'b1;
        end
      end
      DV_SUB: begin
        if (ge) rem_r <= rem_r - dvs_r;
        acc_r <= {acc_r[WIDTH-2:0], 1'b0} + (ge ? mult_r : '0);
        dvs_r <= {1'b0, dvs_r[WIDTH-1:1]};
        cnt_r <= cnt_r - 1'b1;
      end
      default: ;
    endcase
  end

  assign status.busy = (state_r != DV_IDLE);
  assign status.done = done_r;
  assign rem         = rem_r;
  assign acc         = acc_r;

endmodule

/* rtl/core/modular_inverse_extgcd_top.sv */
// Modular inverse by extended Euclid: sequencer, output register and checks.
// Depends on mie_pkg, mie_divser and modular_inverse_extgcd_top_macros.svh.
`include "modular_inverse_extgcd_top_macros.svh"

// Takes value_in and modulus in one input transfer and returns one result:
// the first Bezout coefficient of value_in, reduced into 0 .. modulus-1,
// which is the modular inverse when the two are coprime. A zero modulus
// returns coefficient 0 with bad_modulus (out_tuser) set; it goes straight
// from ST_IDLE to ST_DONE and then into the output register, which raises
// out_tvalid. Otherwise the Euclid loop runs on one shared bit-serial
// divider: each Euclid step starts it, it shifts the divisor up under the
// dividend, then folds one quotient bit per subtract into the product with
// u1. ST_RED and ST_FIX then bring the coefficient into range before
// ST_DONE. At 32 bits the most Euclid steps come from a pair of neighboring
// Fibonacci numbers, with about 46 unit quotients.
// One item is worked at a time; in_tready is high only while the sequencer
// is idle. The result sits in an output register, so a new item may be
// taken while the previous result still waits for its transfer.
module modular_inverse_extgcd_top #(
  parameter int unsigned WIDTH = mie_pkg::WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [((2*WIDTH+7)/8)*8-1:0]        in_tdata,   // value_in, modulus
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [((WIDTH+7)/8)*8-1:0]          out_tdata,  // coefficient
  output logic                                out_tuser   // bad_modulus
);
  import mie_pkg::*;

  mie_state_t       state_r, state_nxt;

  // Euclid registers: remainders, coefficient magnitudes, sign of u0
  logic [WIDTH-1:0] r0_r, r1_r, u0_r, u1_r, mod_r;
  logic             neg_r;

  // Result staging and output register
  logic [WIDTH-1:0] res_r;
  logic             res_bad_r;
  logic [WIDTH-1:0] coef_r;
  logic             bad_r;
  logic             out_vld_r;

  logic [WIDTH-1:0] in_value, in_modulus;
  logic             in_xfer, out_load, div_start;

  div_status_t      div_st;
  logic [WIDTH-1:0] div_rem, div_acc;

  assign in_value   = in_tdata[WIDTH-1:0];
  assign in_modulus = in_tdata[2*WIDTH-1:WIDTH];
  assign in_xfer    = in_tvalid && in_tready;

  mie_divser #(.WIDTH(WIDTH)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (r0_r),
    .divisor  (r1_r),
    .mult     (u1_r),
    .status   (div_st),
    .rem      (div_rem),
    .acc      (div_acc)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = (in_modulus == '0) ? ST_DONE : ST_STEP;
        end
      end
      ST_STEP: begin
        if (r1_r == '0) begin
          state_nxt = ST_RED;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_st.done) state_nxt = ST_STEP;
      end
      ST_RED:  state_nxt = ST_FIX;
      ST_FIX:  state_nxt = ST_DONE;
      ST_DONE: begin
        // wait for the output register to free up
        if (!out_vld_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Euclid datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          r0_r      <= in_value;
          r1_r      <= in_modulus;
          mod_r     <= in_modulus;
          u0_r      <= {{(WIDTH-1){1'b0}}, 1'b1};
          u1_r      <= '0;
          neg_r     <= 1'b0;
          res_r     <= '0;
          res_bad_r <= (in_modulus == '0);
        end
      end
      ST_DIV: begin
        // (r0,r1,u0,u1) <= (r1, r0 mod r1, u1, u0 + q*u1); sign flips each step
        if (div_st.done) begin
          r0_r  <= r1_r;
          r1_r  <= div_rem;
          u0_r  <= u1_r;
          u1_r  <= u0_r + div_acc;
          neg_r <= !neg_r;
        end
      end
      ST_RED: begin
        // |u0| never exceeds the modulus, one subtract reduces it
        if (u0_r >= mod_r) u0_r <= u0_r - mod_r;
      end
      ST_FIX: begin
        res_r     <= (neg_r && (u0_r != '0)) ? (mod_r - u0_r) : u0_r;
        res_bad_r <= 1'b0;
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      coef_r <= res_r;
      bad_r  <= res_bad_r;
    end
  end

  always_comb begin
    out_tdata              = '0;
    out_tdata[WIDTH-1:0]   = coef_r;
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = bad_r;

  // Checks
  `MIE_ASSERT(a_accept_leaves_idle, in_xfer |=> state_r != ST_IDLE, "accepted item did not start")
  `MIE_ASSERT(a_idle_div_quiet, in_tready |-> !div_st.busy, "divider busy while idle")
  `MIE_ASSERT(a_div_done_in_div, div_st.done |-> state_r == ST_DIV, "divider done outside wait")
  `MIE_ASSERT(a_bad_zero, out_vld_r && bad_r |-> coef_r == '0, "bad modulus with nonzero result")
  `MIE_ASSERT_RST(a_reset_clears_out, !rst_n |=> !out_vld_r, "output valid after reset")

endmodule
